@@ hw/rtl/semaphore_table_unit_macros.svh @@
// Assertion macros used by the semaphore table checker.
`ifndef SEMAPHORE_TABLE_UNIT_MACROS_SVH
`define SEMAPHORE_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while the reset input is low.
`define STU_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("semaphore table check failed");

// Next-cycle implication, disabled while the reset input is low.
`define STU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("semaphore table check failed");

`endif

@@ hw/rtl/stu_pkg.sv @@
// Shared types, codes and defaults of the semaphore table unit.
`default_nettype none
package stu_pkg;

    // Default table geometry.
    localparam int NUM_SEMS_DEF  = 16;
    localparam int NUM_PRIOS_DEF = 32;

    // Command codes.
    localparam logic [2:0] CMD_CREATE_CNT = 3'd0;
    localparam logic [2:0] CMD_CREATE_BIN = 3'd1;
    localparam logic [2:0] CMD_DELETE     = 3'd2;
    localparam logic [2:0] CMD_PEND       = 3'd3;
    localparam logic [2:0] CMD_POST       = 3'd4;
    localparam logic [2:0] CMD_CANCEL     = 3'd5;

    // Status codes.
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_QUEUED      = 3'd1;
    localparam logic [2:0] ST_IRQ         = 3'd2;
    localparam logic [2:0] ST_NOT_CREATED = 3'd3;
    localparam logic [2:0] ST_FULL        = 3'd4;
    localparam logic [2:0] ST_UNAVAIL     = 3'd5;
    localparam logic [2:0] ST_TIMEOUT     = 3'd6;
    localparam logic [2:0] ST_OVF         = 3'd7;

    // Largest count a counting semaphore holds.
    localparam logic [7:0] COUNT_MAX = 8'd255;

    // Operation class decided by the front end.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_IRQ,
        OP_BADID,
        OP_CREATE_CNT,
        OP_CREATE_BIN,
        OP_DELETE,
        OP_PEND,
        OP_POST,
        OP_CANCEL
    } t_op;

    // Classified request passed from the front end to the back end.
    typedef struct packed {
        t_op        op;
        logic [3:0] id;
        logic [7:0] init;
        logic [4:0] prio;
        logic       may_wait;
    } t_op_req;

    // One result item.
    typedef struct packed {
        logic [2:0] status;
        logic [3:0] handle;
        logic       woken_valid;
        logic [4:0] woken_prio;
    } t_result;

endpackage
`default_nettype wire

@@ hw/rtl/stu_front.sv @@
// Front end: accepts requests, classifies them and queues them for execution.
`default_nettype none
module stu_front #(
    parameter int NUM_SEMS  = stu_pkg::NUM_SEMS_DEF,
    parameter int NUM_PRIOS = stu_pkg::NUM_PRIOS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            push,
    output logic                 full,
    input  wire logic [2:0]      i_cmd,
    input  wire logic [3:0]      i_sem_id,
    input  wire logic [7:0]      i_init_value,
    input  wire logic [4:0]      i_priority_req,
    input  wire logic            i_may_wait,
    input  wire logic            i_from_interrupt,
    output stu_pkg::t_op_req     o_req,
    output logic                 o_req_valid,
    input  wire logic            i_req_take
);

    stu_pkg::t_op_req r_slot [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_cnt;
    stu_pkg::t_op_req cls;
    logic             bad_id;
    logic             do_push;
    logic             do_pop;

    // Entry index check.
    assign bad_id = (9'(i_sem_id) >= 9'(NUM_SEMS));

    // Classify the incoming request and clamp its priority; the interrupt check comes first.
    always_comb begin
        cls.id       = i_sem_id;
        cls.init     = i_init_value;
        cls.may_wait = i_may_wait;
        if (7'(i_priority_req) >= 7'(NUM_PRIOS)) begin
            cls.prio = 5'(NUM_PRIOS - 1);
        end else begin
            cls.prio = i_priority_req;
        end
        if (i_from_interrupt && (i_cmd inside {stu_pkg::CMD_CREATE_CNT, stu_pkg::CMD_CREATE_BIN,
                                               stu_pkg::CMD_DELETE, stu_pkg::CMD_PEND})) begin
            cls.op = stu_pkg::OP_IRQ;
        end else begin
            case (i_cmd)
                stu_pkg::CMD_CREATE_CNT: cls.op = stu_pkg::OP_CREATE_CNT;
                stu_pkg::CMD_CREATE_BIN: cls.op = stu_pkg::OP_CREATE_BIN;
                stu_pkg::CMD_DELETE:     cls.op = bad_id ? stu_pkg::OP_BADID : stu_pkg::OP_DELETE;
                stu_pkg::CMD_PEND:       cls.op = bad_id ? stu_pkg::OP_BADID : stu_pkg::OP_PEND;
                stu_pkg::CMD_POST:       cls.op = bad_id ? stu_pkg::OP_BADID : stu_pkg::OP_POST;
                stu_pkg::CMD_CANCEL:     cls.op = bad_id ? stu_pkg::OP_BADID : stu_pkg::OP_CANCEL;
                default:                 cls.op = stu_pkg::OP_NOP;
            endcase
        end
    end

    // Two-entry request queue toward the back end.
    assign full        = (r_cnt == 2'd2);
    assign o_req_valid = (r_cnt != 2'd0);
    assign o_req       = r_slot[r_rd_ptr];
    assign do_push     = push && !full;
    assign do_pop      = i_req_take && o_req_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/stu_back.sv @@
// Back end: table storage and the read-modify-write of one entry per request.
`default_nettype none
module stu_back #(
    parameter int NUM_SEMS  = stu_pkg::NUM_SEMS_DEF,
    parameter int NUM_PRIOS = stu_pkg::NUM_PRIOS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire stu_pkg::t_op_req i_req,
    input  wire logic             i_req_valid,
    output logic                  o_req_take,
    output stu_pkg::t_result      o_res,
    output logic                  o_res_valid,
    input  wire logic             i_res_full
);

    localparam int IDX_W  = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
    localparam int PIDX_W = $clog2(NUM_PRIOS);
    localparam int GRP_SZ = 16;
    localparam int NGRP   = (NUM_SEMS + GRP_SZ - 1) / GRP_SZ;
    localparam int GRP_W  = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int PAD    = NGRP * GRP_SZ;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state                 r_state;
    stu_pkg::t_op_req       r_cur;
    logic [NUM_SEMS-1:0]    r_used;

    // Entry storage; contents of entries not in use are never looked at.
    logic [7:0]             mem_count [NUM_SEMS];
    logic                   mem_bin   [NUM_SEMS];
    logic [NUM_PRIOS-1:0]   mem_mask  [NUM_SEMS];
    logic [7:0]             r_rd_count;
    logic                   r_rd_bin;
    logic [NUM_PRIOS-1:0]   r_rd_mask;

    // Registered free-entry summary, one row of sixteen entries per group.
    logic [PAD-1:0]         used_pad;
    logic                   grp_any   [NGRP];
    logic [3:0]             grp_low   [NGRP];
    logic                   r_grp_any [NGRP];
    logic [3:0]             r_grp_low [NGRP];

    logic [IDX_W-1:0]       rd_idx;
    logic [IDX_W-1:0]       cur_idx;
    logic                   cur_used;
    logic                   free_any;
    logic [GRP_W+3:0]       free_wide;
    logic [IDX_W-1:0]       free_idx;
    logic [NUM_PRIOS-1:0]   caller_bit;
    logic [PIDX_W-1:0]      hi_idx;
    logic [6:0]             hi_wide;
    logic                   proceed;

    logic                   wr_en;
    logic [IDX_W-1:0]       wr_idx;
    logic [7:0]             wr_count;
    logic                   wr_bin;
    logic [NUM_PRIOS-1:0]   wr_mask;
    logic                   set_used;
    logic                   clr_used;
    stu_pkg::t_result       res;

    // Index conversion from the fixed-width id field.
    assign rd_idx   = IDX_W'(9'(i_req.id));
    assign cur_idx  = IDX_W'(9'(r_cur.id));
    assign cur_used = r_used[cur_idx];

    // Pad the used bits so that entries beyond the table look taken.
    for (genvar g = 0; g < PAD; g++) begin : g_pad
        if (g < NUM_SEMS) begin : g_real
            assign used_pad[g] = r_used[g];
        end else begin : g_fill
            assign used_pad[g] = 1'b1;
        end
    end

    // Lowest free entry inside each group.
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            grp_any[g] = !(&used_pad[g*GRP_SZ +: GRP_SZ]);
            grp_low[g] = 4'd0;
            for (int b = GRP_SZ - 1; b >= 0; b--) begin
                if (!used_pad[g*GRP_SZ + b]) begin
                    grp_low[g] = 4'(b);
                end
            end
        end
    end

    // Register the group summary.
    always_ff @(posedge i_clk) begin
        for (int g = 0; g < NGRP; g++) begin
            r_grp_any[g] <= grp_any[g];
            r_grp_low[g] <= grp_low[g];
        end
    end

    // First group with a free entry.
    always_comb begin
        free_any  = 1'b0;
        free_wide = '0;
        for (int g = NGRP - 1; g >= 0; g--) begin
            if (r_grp_any[g]) begin
                free_any  = 1'b1;
                free_wide = {GRP_W'(g), r_grp_low[g]};
            end
        end
    end
    assign free_idx = IDX_W'(free_wide);

    // Caller bit and highest waiting priority.
    assign caller_bit = {{(NUM_PRIOS - 1){1'b0}}, 1'b1} << r_cur.prio;

    always_comb begin
        hi_idx = '0;
        for (int p = 0; p < NUM_PRIOS; p++) begin
            if (r_rd_mask[p]) begin
                hi_idx = PIDX_W'(p);
            end
        end
    end
    assign hi_wide = 7'(hi_idx);

    // Execute the request held in r_cur against the entry read when it was taken.
    always_comb begin
        wr_en           = 1'b0;
        wr_idx          = cur_idx;
        wr_count        = r_rd_count;
        wr_bin          = r_rd_bin;
        wr_mask         = r_rd_mask;
        set_used        = 1'b0;
        clr_used        = 1'b0;
        res.status      = stu_pkg::ST_OK;
        res.handle      = 4'd0;
        res.woken_valid = 1'b0;
        res.woken_prio  = 5'd0;
        case (r_cur.op)
            stu_pkg::OP_IRQ: begin
                res.status = stu_pkg::ST_IRQ;
            end
            stu_pkg::OP_BADID: begin
                res.status = stu_pkg::ST_NOT_CREATED;
            end
            stu_pkg::OP_CREATE_CNT, stu_pkg::OP_CREATE_BIN: begin
                if (!free_any) begin
                    res.status = stu_pkg::ST_FULL;
                end else begin
                    wr_en      = 1'b1;
                    wr_idx     = free_idx;
                    wr_bin     = (r_cur.op == stu_pkg::OP_CREATE_BIN);
                    wr_count   = wr_bin ? 8'(r_cur.init != 8'd0) : r_cur.init;
                    wr_mask    = '0;
                    set_used   = 1'b1;
                    res.handle = free_wide[3:0];
                end
            end
            stu_pkg::OP_DELETE: begin
                clr_used = 1'b1;
            end
            stu_pkg::OP_PEND: begin
                if (!cur_used) begin
                    res.status = stu_pkg::ST_NOT_CREATED;
                end else if (r_rd_count != 8'd0) begin
                    wr_en    = 1'b1;
                    wr_count = r_rd_count - 8'd1;
                end else if (!r_cur.may_wait) begin
                    res.status = stu_pkg::ST_UNAVAIL;
                end else begin
                    wr_en      = 1'b1;
                    wr_mask    = r_rd_mask | caller_bit;
                    res.status = stu_pkg::ST_QUEUED;
                end
            end
            stu_pkg::OP_POST: begin
                if (!cur_used) begin
                    res.status = stu_pkg::ST_NOT_CREATED;
                end else if (r_rd_mask != '0) begin
                    wr_en           = 1'b1;
                    wr_mask         = r_rd_mask & ~({{(NUM_PRIOS - 1){1'b0}}, 1'b1} << hi_idx);
                    res.woken_valid = 1'b1;
                    res.woken_prio  = hi_wide[4:0];
                end else if (r_rd_bin) begin
                    wr_en    = 1'b1;
                    wr_count = 8'd1;
                end else if (r_rd_count != stu_pkg::COUNT_MAX) begin
                    wr_en    = 1'b1;
                    wr_count = r_rd_count + 8'd1;
                end else begin
                    res.status = stu_pkg::ST_OVF;
                end
            end
            stu_pkg::OP_CANCEL: begin
                if (!cur_used) begin
                    res.status = stu_pkg::ST_NOT_CREATED;
                end else if ((r_rd_mask & caller_bit) != '0) begin
                    wr_en      = 1'b1;
                    wr_mask    = r_rd_mask & ~caller_bit;
                    res.status = stu_pkg::ST_TIMEOUT;
                end
            end
            default: begin
                res.status = stu_pkg::ST_OK;
            end
        endcase
    end

    assign proceed     = (r_state == S_EXEC) && !i_res_full;
    assign o_req_take  = (r_state == S_IDLE) && i_req_valid;
    assign o_res       = res;
    assign o_res_valid = proceed;

    // Entry memory: read when a request is taken, write when it completes.
    always_ff @(posedge i_clk) begin
        if (o_req_take) begin
            r_rd_count <= mem_count[rd_idx];
            r_rd_bin   <= mem_bin[rd_idx];
            r_rd_mask  <= mem_mask[rd_idx];
        end
        if (proceed && wr_en) begin
            mem_count[wr_idx] <= wr_count;
            mem_bin[wr_idx]   <= wr_bin;
            mem_mask[wr_idx]  <= wr_mask;
        end
    end

    // Sequencer with the held request and the entry-in-use bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_cur   <= i_req;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (proceed) begin
                        if (set_used) begin
                            r_used[wr_idx] <= 1'b1;
                        end
                        if (clr_used) begin
                            r_used[cur_idx] <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/stu_result_q.sv @@
// Two-entry result queue that drives the result ports.
`default_nettype none
module stu_result_q (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire stu_pkg::t_result i_res,
    input  wire logic             i_res_valid,
    output logic                  o_full,
    output logic                  empty,
    input  wire logic             pop,
    output stu_pkg::t_result      o_res
);

    stu_pkg::t_result r_slot [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign empty   = (r_cnt == 2'd0);
    assign o_res   = r_slot[r_rd_ptr];
    assign do_push = i_res_valid && !o_full;
    assign do_pop  = pop && !empty;

    // Result storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_res;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/semaphore_table_unit.sv @@
// An accepted request passes the request queue, then the back end, then the result queue.
// The back end takes a new request only once the last one is done, since each request performs
// the entry memory read then write in turn, and it waits while the result queue is full.
// Up to two requests and two results are buffered on either side.
// Reset is synchronous and active low; it empties both queues and frees all entries.
`default_nettype none
module semaphore_table_unit #(
    parameter int NUM_SEMS  = stu_pkg::NUM_SEMS_DEF,
    parameter int NUM_PRIOS = stu_pkg::NUM_PRIOS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [2:0] i_cmd,
    input  wire logic [3:0] i_sem_id,
    input  wire logic [7:0] i_init_value,
    input  wire logic [4:0] i_priority_req,
    input  wire logic       i_may_wait,
    input  wire logic       i_from_interrupt,
    output logic            empty,
    input  wire logic       pop,
    output logic [2:0]      o_status,
    output logic [3:0]      o_sem_handle,
    output logic            o_woken_valid,
    output logic [4:0]      o_woken_priority
);

    stu_pkg::t_op_req req;
    logic             req_valid;
    logic             req_take;
    stu_pkg::t_result res;
    logic             res_valid;
    logic             res_full;
    stu_pkg::t_result res_out;

    // Request intake and classification.
    stu_front #(
        .NUM_SEMS  (NUM_SEMS),
        .NUM_PRIOS (NUM_PRIOS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_cmd            (i_cmd),
        .i_sem_id         (i_sem_id),
        .i_init_value     (i_init_value),
        .i_priority_req   (i_priority_req),
        .i_may_wait       (i_may_wait),
        .i_from_interrupt (i_from_interrupt),
        .o_req            (req),
        .o_req_valid      (req_valid),
        .i_req_take       (req_take)
    );

    // Table execution.
    stu_back #(
        .NUM_SEMS  (NUM_SEMS),
        .NUM_PRIOS (NUM_PRIOS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req),
        .i_req_valid (req_valid),
        .o_req_take  (req_take),
        .o_res       (res),
        .o_res_valid (res_valid),
        .i_res_full  (res_full)
    );

    // Result buffering.
    stu_result_q u_result_q (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res       (res),
        .i_res_valid (res_valid),
        .o_full      (res_full),
        .empty       (empty),
        .pop         (pop),
        .o_res       (res_out)
    );

    assign o_status         = res_out.status;
    assign o_sem_handle     = res_out.handle;
    assign o_woken_valid    = res_out.woken_valid;
    assign o_woken_priority = res_out.woken_prio;

endmodule
`default_nettype wire

@@ hw/rtl/stu_checker.sv @@
// Port-level checks of the semaphore table unit and their binding.
`default_nettype none
`include "semaphore_table_unit_macros.svh"
module stu_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       push,
    input wire logic       full,
    input wire logic       empty,
    input wire logic       pop,
    input wire logic [2:0] o_status,
    input wire logic [3:0] o_sem_handle,
    input wire logic       o_woken_valid,
    input wire logic [4:0] o_woken_priority
);

    // Reset leaves the result queue empty and the request queue not full.
    `STU_ASSERT_NEXT(a_reset_empty, i_clk, 1'b1, !i_rst_n, empty && !full)

    // Only a successful create returns a nonzero handle.
    `STU_ASSERT_NOW(a_handle_ok, i_clk, i_rst_n, !empty && (o_sem_handle != 4'd0), o_status == stu_pkg::ST_OK)

    // A released waiter comes only with a plain success and no handle.
    `STU_ASSERT_NOW(a_woken_ok, i_clk, i_rst_n, !empty && o_woken_valid, (o_status == stu_pkg::ST_OK) && (o_sem_handle == 4'd0))

    // A waiter priority is reported only together with a release.
    `STU_ASSERT_NOW(a_prio_woken, i_clk, i_rst_n, !empty && (o_woken_priority != 5'd0), o_woken_valid)

    // A waiting result stays until it is popped.
    `STU_ASSERT_NEXT(a_result_holds, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_status))

endmodule

bind semaphore_table_unit stu_checker u_stu_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .push             (push),
    .full             (full),
    .empty            (empty),
    .pop              (pop),
    .o_status         (o_status),
    .o_sem_handle     (o_sem_handle),
    .o_woken_valid    (o_woken_valid),
    .o_woken_priority (o_woken_priority)
);
`default_nettype wire
